[sv/lcs_length_engine_core_assert.svh]
// Assertion macros used by the engine's datapath.
`ifndef LCS_LENGTH_ENGINE_CORE_ASSERT_SVH
`define LCS_LENGTH_ENGINE_CORE_ASSERT_SVH

// Condition that must hold at every edge outside reset.
`define LCS_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("lcs engine: invariant violated");

// Consequence that must hold in the cycle after the antecedent.
`define LCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lcs engine: sequence violated");

`endif

[sv/lcs_pkg.sv]
package lcs_pkg;

   localparam int MAX_LEN = 128;
   // Counter width holds 0..MAX_LEN; address width indexes 0..MAX_LEN-1.
   localparam int CNT_W   = $clog2(MAX_LEN + 1);
   localparam int ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int SYM_W   = 8;
   localparam int LEN_W   = 8;

   localparam logic KIND_A = 1'b0;
   localparam logic KIND_B = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic a_write;
      logic sweep_start;
      logic sweep_run;
      logic sweep_end;
      logic result_load;
   } cmd_type;

   typedef struct packed {
      logic a_complete;
      logic sweep_done;
      logic b_last;
      logic rsp_free;
   } status_type;

endpackage

[sv/lcs_ctrl.sv]
module lcs_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic               req_kind,
   output logic               req_tready,
   input  lcs_pkg::status_type status,
   output lcs_pkg::cmd_type    cmd
);

   lcs_pkg::state_type state_ff;
   lcs_pkg::state_type state_in;
   logic               accept;

   assign req_tready = (state_ff == lcs_pkg::ST_IDLE);
   assign accept     = req_tvalid & req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lcs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lcs_pkg::ST_IDLE: begin
            // A B symbol is only swept once string A is complete.
            if (accept && (req_kind == lcs_pkg::KIND_B) && status.a_complete) begin
               state_in = lcs_pkg::ST_SWEEP;
            end
         end
         lcs_pkg::ST_SWEEP: begin
            if (status.sweep_done) begin
               state_in = status.b_last ? lcs_pkg::ST_FINISH : lcs_pkg::ST_IDLE;
            end
         end
         lcs_pkg::ST_FINISH: begin
            if (status.rsp_free) begin
               state_in = lcs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lcs_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         lcs_pkg::ST_IDLE: begin
            cmd.a_write     = accept && (req_kind == lcs_pkg::KIND_A);
            cmd.sweep_start = accept && (req_kind == lcs_pkg::KIND_B) && status.a_complete;
         end
         lcs_pkg::ST_SWEEP: begin
            cmd.sweep_run = 1'b1;
            cmd.sweep_end = status.sweep_done;
         end
         lcs_pkg::ST_FINISH: begin
            cmd.result_load = status.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

[sv/lcs_datapath.sv]
`include "lcs_length_engine_core_assert.svh"

module lcs_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  lcs_pkg::cmd_type          cmd,
   output lcs_pkg::status_type       status,
   input  logic [lcs_pkg::SYM_W-1:0] req_symbol,
   input  logic                      req_last,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [lcs_pkg::LEN_W-1:0] rsp_length,
   output logic                      rsp_truncated
);

   // Stored string A and the dynamic-programming row (entry k holds row
   // position k+1; position 0 is always zero).
   logic [lcs_pkg::SYM_W-1:0] a_mem  [lcs_pkg::MAX_LEN];
   logic [lcs_pkg::CNT_W-1:0] dp_mem [lcs_pkg::MAX_LEN];

   logic [lcs_pkg::CNT_W-1:0]  a_count_ff,    a_count_in;
   logic                       a_ovf_ff,      a_ovf_in;
   logic                       a_complete_ff, a_complete_in;
   logic                       fresh_ff,      fresh_in;
   logic [lcs_pkg::CNT_W-1:0]  issue_cnt_ff,  issue_cnt_in;
   logic                       pipe_vld_ff,   pipe_vld_in;
   logic                       rsp_vld_ff,    rsp_vld_in;

   logic [lcs_pkg::SYM_W-1:0]  store_rd_ff;
   logic [lcs_pkg::CNT_W-1:0]  dp_rd_ff;
   logic [lcs_pkg::ADDR_W-1:0] wr_addr_ff;
   logic [lcs_pkg::SYM_W-1:0]  b_sym_ff;
   logic                       b_last_ff;
   logic [lcs_pkg::CNT_W-1:0]  diag_ff,       diag_in;
   logic [lcs_pkg::CNT_W-1:0]  left_ff,       left_in;
   logic [lcs_pkg::LEN_W-1:0]  rsp_len_ff;
   logic                       rsp_trunc_ff;

   logic [lcs_pkg::CNT_W-1:0]  eff_count;
   logic                       eff_ovf;
   logic                       a_store;
   logic                       issue;
   logic                       cell_wr;
   logic [lcs_pkg::CNT_W-1:0]  above;
   logic [lcs_pkg::CNT_W-1:0]  cell_val;

   // A symbol arriving after a complete A begins a new string.
   assign eff_count = a_complete_ff ? '0 : a_count_ff;
   assign eff_ovf   = a_complete_ff ? 1'b0 : a_ovf_ff;
   assign a_store   = cmd.a_write && (eff_count < lcs_pkg::CNT_W'(lcs_pkg::MAX_LEN));

   assign issue   = cmd.sweep_run && (issue_cnt_ff < a_count_ff);
   assign cell_wr = cmd.sweep_run && pipe_vld_ff;
   // Right after A ends the row is all zero, without a clearing pass.
   assign above   = fresh_ff ? '0 : dp_rd_ff;

   always_comb begin
      if (store_rd_ff == b_sym_ff) begin
         cell_val = lcs_pkg::CNT_W'(diag_ff + 1'b1);
      end else if (left_ff > above) begin
         cell_val = left_ff;
      end else begin
         cell_val = above;
      end
   end

   always_comb begin
      a_count_in    = a_count_ff;
      a_ovf_in      = a_ovf_ff;
      a_complete_in = a_complete_ff;
      fresh_in      = fresh_ff;
      issue_cnt_in  = issue_cnt_ff;
      pipe_vld_in   = 1'b0;
      diag_in       = diag_ff;
      left_in       = left_ff;
      rsp_vld_in    = rsp_vld_ff && !rsp_tready;

      if (cmd.a_write) begin
         a_count_in    = a_store ? lcs_pkg::CNT_W'(eff_count + 1'b1) : eff_count;
         a_ovf_in      = eff_ovf || !a_store;
         a_complete_in = req_last;
         if (req_last) begin
            fresh_in = 1'b1;
         end
      end
      if (cmd.sweep_start) begin
         issue_cnt_in = '0;
         diag_in      = '0;
         left_in      = '0;
      end
      if (issue) begin
         issue_cnt_in = lcs_pkg::CNT_W'(issue_cnt_ff + 1'b1);
         pipe_vld_in  = 1'b1;
      end
      if (cell_wr) begin
         left_in = cell_val;
         diag_in = above;
      end
      if (cmd.sweep_end) begin
         fresh_in = 1'b0;
      end
      if (cmd.result_load) begin
         rsp_vld_in    = 1'b1;
         a_count_in    = '0;
         a_ovf_in      = 1'b0;
         a_complete_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_count_ff    <= '0;
         a_ovf_ff      <= 1'b0;
         a_complete_ff <= 1'b0;
         fresh_ff      <= 1'b1;
         issue_cnt_ff  <= '0;
         pipe_vld_ff   <= 1'b0;
         rsp_vld_ff    <= 1'b0;
      end else begin
         a_count_ff    <= a_count_in;
         a_ovf_ff      <= a_ovf_in;
         a_complete_ff <= a_complete_in;
         fresh_ff      <= fresh_in;
         issue_cnt_ff  <= issue_cnt_in;
         pipe_vld_ff   <= pipe_vld_in;
         rsp_vld_ff    <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      diag_ff    <= diag_in;
      left_ff    <= left_in;
      wr_addr_ff <= issue_cnt_ff[lcs_pkg::ADDR_W-1:0];
      if (cmd.sweep_start) begin
         b_sym_ff  <= req_symbol;
         b_last_ff <= req_last;
      end
      if (cmd.result_load) begin
         rsp_len_ff   <= lcs_pkg::LEN_W'(left_ff);
         rsp_trunc_ff <= a_ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_store) begin
         a_mem[eff_count[lcs_pkg::ADDR_W-1:0]] <= req_symbol;
      end
      store_rd_ff <= a_mem[issue_cnt_ff[lcs_pkg::ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cell_wr) begin
         dp_mem[wr_addr_ff] <= cell_val;
      end
      dp_rd_ff <= dp_mem[issue_cnt_ff[lcs_pkg::ADDR_W-1:0]];
   end

   assign status.a_complete = a_complete_ff;
   assign status.sweep_done = cell_wr && !issue;
   assign status.b_last     = b_last_ff;
   assign status.rsp_free   = !rsp_vld_ff || rsp_tready;

   assign rsp_tvalid    = rsp_vld_ff;
   assign rsp_length    = rsp_len_ff;
   assign rsp_truncated = rsp_trunc_ff;

   `LCS_ASSERT_ALWAYS(a_count_bound, clock, reset, a_count_ff <= lcs_pkg::CNT_W'(lcs_pkg::MAX_LEN))
   `LCS_ASSERT_ALWAYS(issue_bound, clock, reset, !cmd.sweep_run || (issue_cnt_ff <= a_count_ff))
   `LCS_ASSERT_NEXT(result_clears_a, clock, reset, cmd.result_load, !a_complete_ff && rsp_vld_ff)

endmodule

[sv/lcs_length_engine_core.sv]
// An A symbol is taken whenever the input is open; a B symbol holds the input closed during its
// row sweep. After the sweep of the final B symbol ends, the controller enters its finish state
// and, once the output register is free, loads the result into it; the input stays closed until
// the result has been handed over. One A symbol per cycle while the input is open; the row sweep
// reads one A position and one row entry per cycle, and the input takes no new symbol until it ends.
// Reset (synchronous, active high) clears all control state; the row reads as zero after A.
module lcs_length_engine_core (
   input  logic                      clock,
   input  logic                      reset,
   // Input channel: one symbol of string A or string B per transaction.
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [lcs_pkg::SYM_W-1:0] req_tdata,   // [7:0] symbol
   input  logic                      req_tuser,   // [0] kind: 0 = string A, 1 = string B
   input  logic                      req_tlast,   // final symbol of that string
   // Result channel: one transaction after the last symbol of B.
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [lcs_pkg::LEN_W-1:0] rsp_tdata,   // [7:0] lcs_length
   output logic                      rsp_tuser    // [0] truncated
);

   // The controller sequences string capture, the row sweep per B symbol and
   // the hand-over of the result into the output register; the datapath holds
   // both memories, the sweep pipeline and the output register. The row is
   // marked fresh when A ends, so it reads as zero without a clearing pass.
   lcs_pkg::cmd_type    cmd;
   lcs_pkg::status_type status;

   lcs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_kind   (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Each sweep issues one read per stored A position and writes the updated row
   // entry in the cycle after the read, carrying the left and diagonal values in registers.
   lcs_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_symbol    (req_tdata),
      .req_last      (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_length    (rsp_tdata),
      .rsp_truncated (rsp_tuser)
   );

endmodule
